// ----- rtl/rtn_pkg.sv -----
`default_nettype none

package rtn_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 12;
    localparam int LUMA_ADDR_W   = 22;
    localparam int CHROMA_ADDR_W = 21;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int REG_IDX_LSB   = 2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(224);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(256);
    localparam logic [CFG_W-1:0] FRAME_SIZE_MIN   = CFG_W'(2);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // BT.601 coefficients in thousandths
    localparam int KM_YR = 257;
    localparam int KM_YG = 504;
    localparam int KM_YB = 98;
    localparam int KM_UR = 148;
    localparam int KM_UG = 291;
    localparam int KM_UB = 439;
    localparam int KM_VR = 439;
    localparam int KM_VG = 368;
    localparam int KM_VB = 71;
    localparam int KM_SCALE = 1000;
    localparam int KM_ROUND = 500;
    localparam int OFS_Y    = 16;
    localparam int OFS_C    = 128;

    typedef struct packed {
        logic                     col_odd;
        logic                     row_odd;
        logic                     frame_end;
        logic [LUMA_ADDR_W-1:0]   luma_addr;
        logic [CHROMA_ADDR_W-1:0] chroma_addr;
    } t_pos_info;

endpackage

`default_nettype wire

// ----- rtl/rtn_pixel_if.sv -----
`default_nettype none

interface rtn_pixel_if import rtn_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/rtn_result_if.sv -----
`default_nettype none

interface rtn_result_if import rtn_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [PIX_W-1:0]         luma;
    logic [LUMA_ADDR_W-1:0]   luma_address;
    logic                     chroma_valid;
    logic [PIX_W-1:0]         chroma_u;
    logic [PIX_W-1:0]         chroma_v;
    logic [CHROMA_ADDR_W-1:0] chroma_address;
    logic                     frame_end;

    modport source (
        output valid, output luma, output luma_address, output chroma_valid,
        output chroma_u, output chroma_v, output chroma_address, output frame_end,
        input ready
    );
    modport sink (
        input valid, input luma, input luma_address, input chroma_valid,
        input chroma_u, input chroma_v, input chroma_address, input frame_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/rgb_to_nv12_converter_top.sv -----
`default_nettype none

// RGB to NV12 (BT.601 limited range) converter. Accepts one RGB pixel per clock
// in raster order unless the result side stalls, and returns one transaction per
// pixel through its input, component and result registers: luma and its Y-plane
// offset on every pixel, plus 2x2-averaged U/V and the UV-plane offset of the U
// byte on the pixel that closes a block (odd row, odd column). Sustained rate is
// one pixel per cycle without stalls, set by the three-register pipeline and the
// line store with one write and one read port per cycle. The line store holds
// MAX_WIDTH/2 pair sums for U and V; it is not cleared at reset, and each entry
// is written on an even row before the following odd row reads it. Frame width
// and height sit at APB offsets 0x0 and 0x4 (12 bits, clamped to 2..MAX_WIDTH
// and 2..MAX_HEIGHT); a write to either restarts the frame at row 0, column 0.
// The user must write only while no transaction is in flight (not enforced).
module rgb_to_nv12_converter_top import rtn_pkg::*; #(
    parameter int MAX_WIDTH      = 2048,
    parameter int MAX_HEIGHT     = 2048,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    rtn_pixel_if.sink             i_pixel,
    rtn_result_if.source          o_result
);

    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int HW    = $clog2(MAX_HEIGHT+1);
    localparam int IDX_W = $clog2(MAX_WIDTH/2);

    logic [WW-1:0]    w_width;
    logic [HW-1:0]    w_height;
    logic             w_restart;
    logic             w_ready;
    logic             w_accept;
    t_pos_info        w_pos;
    logic [IDX_W-1:0] w_line_idx;

    assign i_pixel.ready = w_ready;
    assign w_accept      = i_pixel.valid & w_ready;

    rtn_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_width   (w_width),
        .o_height  (w_height),
        .o_restart (w_restart)
    );

    rtn_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_restart  (w_restart),
        .i_width    (w_width),
        .i_height   (w_height),
        .o_pos      (w_pos),
        .o_line_idx (w_line_idx)
    );

    rtn_color_pipe #(
        .MAX_WIDTH      (MAX_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_color_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_pixel.valid),
        .o_ready          (w_ready),
        .i_red            (i_pixel.red),
        .i_green          (i_pixel.green),
        .i_blue           (i_pixel.blue),
        .i_pos            (w_pos),
        .i_line_idx       (w_line_idx),
        .o_valid          (o_result.valid),
        .i_ready          (o_result.ready),
        .o_luma           (o_result.luma),
        .o_luma_address   (o_result.luma_address),
        .o_chroma_valid   (o_result.chroma_valid),
        .o_chroma_u       (o_result.chroma_u),
        .o_chroma_v       (o_result.chroma_v),
        .o_chroma_address (o_result.chroma_address),
        .o_frame_end      (o_result.frame_end)
    );

endmodule

`default_nettype wire

// ----- rtl/rtn_cfg_regs.sv -----
`default_nettype none

module rtn_cfg_regs import rtn_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_ADDR_W-1:0]               paddr,
    input  logic [APB_DATA_W-1:0]               pwdata,
    output logic [APB_DATA_W-1:0]               prdata,
    output logic                                pready,
    output logic [$clog2(MAX_WIDTH+1)-1:0]      o_width,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]     o_height,
    output logic                                o_restart
);

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CFG_W-1:0] n_frame_width;
    logic [CFG_W-1:0] n_frame_height;
    logic             w_write;
    t_reg_idx         w_reg_idx;

    assign pready    = 1'b1;
    assign w_write   = psel & penable & pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[REG_IDX_LSB]);
    assign o_restart = w_write;

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        if (w_write) begin
            case (w_reg_idx)
                REG_FRAME_WIDTH:  n_frame_width  = pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: n_frame_height = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_frame_width < FRAME_SIZE_MIN) begin
            o_width = WW'(FRAME_SIZE_MIN);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            o_width = WW'(MAX_WIDTH);
        end else begin
            o_width = WW'(r_frame_width);
        end
    end

    always_comb begin
        if (r_frame_height < FRAME_SIZE_MIN) begin
            o_height = HW'(FRAME_SIZE_MIN);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            o_height = HW'(MAX_HEIGHT);
        end else begin
            o_height = HW'(r_frame_height);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rtn_position.sv -----
`default_nettype none

module rtn_position import rtn_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_height,
    output t_pos_info                           o_pos,
    output logic [$clog2(MAX_WIDTH/2)-1:0]      o_line_idx
);

    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int HW    = $clog2(MAX_HEIGHT+1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int IDX_W = $clog2(MAX_WIDTH/2);

    logic [CW-1:0]            r_col;
    logic [RW-1:0]            r_row;
    logic [LUMA_ADDR_W-1:0]   r_luma_addr;
    logic [CHROMA_ADDR_W-1:0] r_chroma_base;
    logic [CW-1:0]            n_col;
    logic [RW-1:0]            n_row;
    logic [LUMA_ADDR_W-1:0]   n_luma_addr;
    logic [CHROMA_ADDR_W-1:0] n_chroma_base;
    logic                     w_last_col;
    logic                     w_last_row;

    assign w_last_col = (WW'(r_col) + WW'(1)) >= i_width;
    assign w_last_row = (HW'(r_row) + HW'(1)) >= i_height;

    assign o_pos.col_odd     = r_col[0];
    assign o_pos.row_odd     = r_row[0];
    assign o_pos.frame_end   = w_last_col & w_last_row;
    assign o_pos.luma_addr   = r_luma_addr;
    assign o_pos.chroma_addr = r_chroma_base + CHROMA_ADDR_W'({r_col[CW-1:1], 1'b0});
    assign o_line_idx        = r_col[IDX_W:1];

    always_comb begin
        n_col         = r_col;
        n_row         = r_row;
        n_luma_addr   = r_luma_addr;
        n_chroma_base = r_chroma_base;
        if (i_restart) begin
            n_col         = '0;
            n_row         = '0;
            n_luma_addr   = '0;
            n_chroma_base = '0;
        end else if (i_accept) begin
            n_luma_addr = r_luma_addr + LUMA_ADDR_W'(1);
            if (!w_last_col) begin
                n_col = r_col + CW'(1);
            end else begin
                n_col = '0;
                if (w_last_row) begin
                    n_row         = '0;
                    n_luma_addr   = '0;
                    n_chroma_base = '0;
                end else begin
                    n_row = r_row + RW'(1);
                    if (r_row[0]) begin
                        n_chroma_base = r_chroma_base
                                      + CHROMA_ADDR_W'({i_width[WW-1:1], 1'b0});
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_luma_addr   <= '0;
            r_chroma_base <= '0;
        end else begin
            r_col         <= n_col;
            r_row         <= n_row;
            r_luma_addr   <= n_luma_addr;
            r_chroma_base <= n_chroma_base;
        end
    end

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < i_width)
        else $error("column counter beyond frame width");

    a_wrap_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_restart && o_pos.frame_end)
        |=> (r_col == '0 && r_row == '0 && r_luma_addr == '0 && r_chroma_base == '0))
        else $error("counters did not wrap after last pixel");

    a_row_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_restart && !w_last_col) |=> (r_row == $past(r_row)))
        else $error("row advanced inside a line");

endmodule

`default_nettype wire

// ----- rtl/rtn_color_pipe.sv -----
`default_nettype none

module rtn_color_pipe import rtn_pkg::*; #(
    parameter int MAX_WIDTH      = 2048,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [PIX_W-1:0]                 i_red,
    input  logic [PIX_W-1:0]                 i_green,
    input  logic [PIX_W-1:0]                 i_blue,
    input  t_pos_info                        i_pos,
    input  logic [$clog2(MAX_WIDTH/2)-1:0]   i_line_idx,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [PIX_W-1:0]                 o_luma,
    output logic [LUMA_ADDR_W-1:0]           o_luma_address,
    output logic                             o_chroma_valid,
    output logic [PIX_W-1:0]                 o_chroma_u,
    output logic [PIX_W-1:0]                 o_chroma_v,
    output logic [CHROMA_ADDR_W-1:0]         o_chroma_address,
    output logic                             o_frame_end
);

    localparam int ACC_W      = COEF_FRAC_BITS + 10;
    localparam int PAIR_W     = ACC_W + 1;
    localparam int SUM_W      = ACC_W + 2;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W      = $clog2(LINE_DEPTH);

    localparam logic signed [ACC_W-1:0] KYR =
        ACC_W'(((KM_YR << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] KYG =
        ACC_W'(((KM_YG << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] KYB =
        ACC_W'(((KM_YB << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] KUR =
        ACC_W'(((KM_UR << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] KUG =
        ACC_W'(((KM_UG << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] KUB =
        ACC_W'(((KM_UB << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] KVR =
        ACC_W'(((KM_VR << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] KVG =
        ACC_W'(((KM_VG << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] KVB =
        ACC_W'(((KM_VB << COEF_FRAC_BITS) + KM_ROUND) / KM_SCALE);
    localparam logic signed [ACC_W-1:0] Y_OFS  = ACC_W'(OFS_Y << COEF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] C_OFS  = ACC_W'(OFS_C << COEF_FRAC_BITS);
    localparam logic signed [SUM_W-1:0] Y_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] C_HALF = SUM_W'(1) << (COEF_FRAC_BITS + 1);

    function automatic logic [PIX_W-1:0] f_clip8(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v[SUM_W-1]) begin
            res = '0;
        end else if (|v[SUM_W-2:PIX_W]) begin
            res = '1;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    // stage 1: input register
    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_red;
    logic [PIX_W-1:0]   r_s1_green;
    logic [PIX_W-1:0]   r_s1_blue;
    t_pos_info          r_s1_pos;
    logic [IDX_W-1:0]   r_s1_idx;

    // stage 2: fixed-point components and line store read
    logic                     r_s2_valid;
    logic signed [ACC_W-1:0]  r_s2_y_acc;
    logic signed [ACC_W-1:0]  r_s2_u_acc;
    logic signed [ACC_W-1:0]  r_s2_v_acc;
    t_pos_info                r_s2_pos;
    logic [IDX_W-1:0]         r_s2_idx;
    logic signed [PAIR_W-1:0] r_s2_upper_u;
    logic signed [PAIR_W-1:0] r_s2_upper_v;

    // stage 3: result register
    logic                     r_s3_valid;
    logic [PIX_W-1:0]         r_s3_luma;
    logic [LUMA_ADDR_W-1:0]   r_s3_luma_addr;
    logic                     r_s3_chroma_valid;
    logic [PIX_W-1:0]         r_s3_chroma_u;
    logic [PIX_W-1:0]         r_s3_chroma_v;
    logic [CHROMA_ADDR_W-1:0] r_s3_chroma_addr;
    logic                     r_s3_frame_end;

    logic signed [ACC_W-1:0]  r_left_u;
    logic signed [ACC_W-1:0]  r_left_v;
    logic signed [PAIR_W-1:0] r_line_u [LINE_DEPTH];
    logic signed [PAIR_W-1:0] r_line_v [LINE_DEPTH];

    logic                     w_adv;
    logic signed [ACC_W-1:0]  w_red;
    logic signed [ACC_W-1:0]  w_green;
    logic signed [ACC_W-1:0]  w_blue;
    logic signed [ACC_W-1:0]  w_y_acc;
    logic signed [ACC_W-1:0]  w_u_acc;
    logic signed [ACC_W-1:0]  w_v_acc;
    logic signed [PAIR_W-1:0] w_pair_u;
    logic signed [PAIR_W-1:0] w_pair_v;
    logic signed [SUM_W-1:0]  w_quad_u;
    logic signed [SUM_W-1:0]  w_quad_v;
    logic signed [SUM_W-1:0]  w_y_rnd;
    logic signed [SUM_W-1:0]  w_u_rnd;
    logic signed [SUM_W-1:0]  w_v_rnd;
    logic                     w_chroma;
    logic                     w_line_we;
    logic                     w_left_we;

    assign w_adv   = !r_s3_valid || i_ready;
    assign o_ready = w_adv;

    assign w_red   = $signed(ACC_W'(r_s1_red));
    assign w_green = $signed(ACC_W'(r_s1_green));
    assign w_blue  = $signed(ACC_W'(r_s1_blue));
    assign w_y_acc = KYR * w_red + KYG * w_green + KYB * w_blue + Y_OFS;
    assign w_u_acc = KUB * w_blue - KUR * w_red - KUG * w_green + C_OFS;
    assign w_v_acc = KVR * w_red - KVG * w_green - KVB * w_blue + C_OFS;

    assign w_pair_u = PAIR_W'(r_left_u) + PAIR_W'(r_s2_u_acc);
    assign w_pair_v = PAIR_W'(r_left_v) + PAIR_W'(r_s2_v_acc);
    assign w_quad_u = SUM_W'(r_s2_upper_u) + SUM_W'(r_left_u) + SUM_W'(r_s2_u_acc);
    assign w_quad_v = SUM_W'(r_s2_upper_v) + SUM_W'(r_left_v) + SUM_W'(r_s2_v_acc);
    assign w_y_rnd  = (SUM_W'(r_s2_y_acc) + Y_HALF) >>> COEF_FRAC_BITS;
    assign w_u_rnd  = (w_quad_u + C_HALF) >>> (COEF_FRAC_BITS + 2);
    assign w_v_rnd  = (w_quad_v + C_HALF) >>> (COEF_FRAC_BITS + 2);

    assign w_chroma  = r_s2_pos.col_odd & r_s2_pos.row_odd;
    assign w_line_we = w_adv & r_s2_valid & r_s2_pos.col_odd & !r_s2_pos.row_odd;
    assign w_left_we = w_adv & r_s2_valid & !r_s2_pos.col_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
            r_s1_pos   <= i_pos;
            r_s1_idx   <= i_line_idx;

            r_s2_y_acc <= w_y_acc;
            r_s2_u_acc <= w_u_acc;
            r_s2_v_acc <= w_v_acc;
            r_s2_pos   <= r_s1_pos;
            r_s2_idx   <= r_s1_idx;

            r_s3_luma         <= f_clip8(w_y_rnd);
            r_s3_luma_addr    <= r_s2_pos.luma_addr;
            r_s3_chroma_valid <= w_chroma;
            r_s3_chroma_u     <= w_chroma ? f_clip8(w_u_rnd) : '0;
            r_s3_chroma_v     <= w_chroma ? f_clip8(w_v_rnd) : '0;
            r_s3_chroma_addr  <= w_chroma ? r_s2_pos.chroma_addr : '0;
            r_s3_frame_end    <= r_s2_pos.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_u <= '0;
            r_left_v <= '0;
        end else if (w_left_we) begin
            r_left_u <= r_s2_u_acc;
            r_left_v <= r_s2_v_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_upper_u <= r_line_u[r_s1_idx];
            r_s2_upper_v <= r_line_v[r_s1_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_line_we) begin
            r_line_u[r_s2_idx] <= w_pair_u;
            r_line_v[r_s2_idx] <= w_pair_v;
        end
    end

    assign o_valid          = r_s3_valid;
    assign o_luma           = r_s3_luma;
    assign o_luma_address   = r_s3_luma_addr;
    assign o_chroma_valid   = r_s3_chroma_valid;
    assign o_chroma_u       = r_s3_chroma_u;
    assign o_chroma_v       = r_s3_chroma_v;
    assign o_chroma_address = r_s3_chroma_addr;
    assign o_frame_end      = r_s3_frame_end;

    a_chroma_addr_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_chroma_valid) |-> !o_chroma_address[0])
        else $error("chroma address not on a U byte");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_chroma_valid)
        |-> (o_chroma_u == '0 && o_chroma_v == '0 && o_chroma_address == '0))
        else $error("chroma fields set without a completed block");

    a_block_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s2_valid && r_s2_pos.col_odd && r_s2_pos.row_odd)
        |=> (o_valid && o_chroma_valid))
        else $error("completed block lost on its way to the result register");

endmodule

`default_nettype wire
